>>> hdl/crm_pkg.sv
// shared types, register codes and reset values of the cell range and average monitor
package crm_pkg;

    localparam int VAL_W         = 12;
    localparam int IDX_W         = 5;
    localparam int REG_IDX_W     = 3;
    localparam int CELLS_DEFAULT = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VOLT_CELL_MIN = 3'd0,
        REG_VOLT_CELL_MAX = 3'd1,
        REG_VOLT_MEAN_MIN = 3'd2,
        REG_VOLT_MEAN_MAX = 3'd3,
        REG_TEMP_CELL_MIN = 3'd4,
        REG_TEMP_CELL_MAX = 3'd5,
        REG_TEMP_MEAN_MIN = 3'd6,
        REG_TEMP_MEAN_MAX = 3'd7
    } reg_idx_t;

    localparam logic [VAL_W-1:0] VOLT_CELL_MIN_RST = 12'd100;
    localparam logic [VAL_W-1:0] VOLT_CELL_MAX_RST = 12'd240;
    localparam logic [VAL_W-1:0] VOLT_MEAN_MIN_RST = 12'd120;
    localparam logic [VAL_W-1:0] VOLT_MEAN_MAX_RST = 12'd220;
    localparam logic [VAL_W-1:0] TEMP_CELL_MIN_RST = 12'd50;
    localparam logic [VAL_W-1:0] TEMP_CELL_MAX_RST = 12'd85;
    localparam logic [VAL_W-1:0] TEMP_MEAN_MIN_RST = 12'd55;
    localparam logic [VAL_W-1:0] TEMP_MEAN_MAX_RST = 12'd80;

    localparam logic KIND_VOLT = 1'b0;
    localparam logic KIND_TEMP = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_VOLT = 2'd1,
        FAULT_TEMP = 2'd2
    } fault_t;

    typedef struct packed {
        logic             reading_kind;
        logic [VAL_W-1:0] reading_value;
    } reading_t;

    typedef struct packed {
        logic [1:0]       fault_kind;
        logic             on_mean;
        logic [IDX_W-1:0] cell_index;
        logic [VAL_W-1:0] fault_value;
    } verdict_t;

    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } cell_win_t;

    // end-of-scan summary handed from the accumulator to the verdict stage
    typedef struct packed {
        logic             kind;
        logic             cell_fault;
        logic [IDX_W-1:0] cell_index;
        logic [VAL_W-1:0] cell_value;
    } scan_info_t;

endpackage

>>> hdl/crm_cfg.sv
// threshold registers, mean bounds kept pre-scaled by the scan length
module crm_cfg #(
    parameter int CELLS = crm_pkg::CELLS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [crm_pkg::REG_IDX_W-1:0]         cfg_wr_index,
    input  logic [crm_pkg::VAL_W-1:0]             cfg_wr_data,
    output crm_pkg::cell_win_t [1:0]              cell_win,
    output logic [1:0][crm_pkg::VAL_W+$clog2(CELLS)-1:0] mean_lo,
    output logic [1:0][crm_pkg::VAL_W+$clog2(CELLS)-1:0] mean_hi
);

    localparam int SUM_W = crm_pkg::VAL_W + $clog2(CELLS);

    localparam logic [SUM_W-1:0] V_LO_RST =
        SUM_W'(crm_pkg::VOLT_MEAN_MIN_RST) * SUM_W'(CELLS);
    localparam logic [SUM_W-1:0] V_HI_RST =
        SUM_W'(crm_pkg::VOLT_MEAN_MAX_RST) * SUM_W'(CELLS);
    localparam logic [SUM_W-1:0] T_LO_RST =
        SUM_W'(crm_pkg::TEMP_MEAN_MIN_RST) * SUM_W'(CELLS);
    localparam logic [SUM_W-1:0] T_HI_RST =
        SUM_W'(crm_pkg::TEMP_MEAN_MAX_RST) * SUM_W'(CELLS);

    crm_pkg::cell_win_t [1:0]    cell_win_reg, cell_win_next;
    logic [1:0][SUM_W-1:0]       mean_lo_reg, mean_lo_next;
    logic [1:0][SUM_W-1:0]       mean_hi_reg, mean_hi_next;
    logic [SUM_W-1:0]            data_scaled;

    assign data_scaled = SUM_W'(cfg_wr_data) * SUM_W'(CELLS);

    always_comb begin
        cell_win_next = cell_win_reg;
        mean_lo_next  = mean_lo_reg;
        mean_hi_next  = mean_hi_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                crm_pkg::REG_VOLT_CELL_MIN: cell_win_next[crm_pkg::KIND_VOLT].lo = cfg_wr_data;
                crm_pkg::REG_VOLT_CELL_MAX: cell_win_next[crm_pkg::KIND_VOLT].hi = cfg_wr_data;
                crm_pkg::REG_VOLT_MEAN_MIN: mean_lo_next[crm_pkg::KIND_VOLT] = data_scaled;
                crm_pkg::REG_VOLT_MEAN_MAX: mean_hi_next[crm_pkg::KIND_VOLT] = data_scaled;
                crm_pkg::REG_TEMP_CELL_MIN: cell_win_next[crm_pkg::KIND_TEMP].lo = cfg_wr_data;
                crm_pkg::REG_TEMP_CELL_MAX: cell_win_next[crm_pkg::KIND_TEMP].hi = cfg_wr_data;
                crm_pkg::REG_TEMP_MEAN_MIN: mean_lo_next[crm_pkg::KIND_TEMP] = data_scaled;
                crm_pkg::REG_TEMP_MEAN_MAX: mean_hi_next[crm_pkg::KIND_TEMP] = data_scaled;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_win_reg[crm_pkg::KIND_VOLT].lo <= crm_pkg::VOLT_CELL_MIN_RST;
            cell_win_reg[crm_pkg::KIND_VOLT].hi <= crm_pkg::VOLT_CELL_MAX_RST;
            cell_win_reg[crm_pkg::KIND_TEMP].lo <= crm_pkg::TEMP_CELL_MIN_RST;
            cell_win_reg[crm_pkg::KIND_TEMP].hi <= crm_pkg::TEMP_CELL_MAX_RST;
            mean_lo_reg[crm_pkg::KIND_VOLT]     <= V_LO_RST;
            mean_hi_reg[crm_pkg::KIND_VOLT]     <= V_HI_RST;
            mean_lo_reg[crm_pkg::KIND_TEMP]     <= T_LO_RST;
            mean_hi_reg[crm_pkg::KIND_TEMP]     <= T_HI_RST;
        end else begin
            cell_win_reg <= cell_win_next;
            mean_lo_reg  <= mean_lo_next;
            mean_hi_reg  <= mean_hi_next;
        end
    end

    assign cell_win = cell_win_reg;
    assign mean_lo  = mean_lo_reg;
    assign mean_hi  = mean_hi_reg;

endmodule

>>> hdl/crm_acc.sv
// input register, per-cell window check and scan accumulator
module crm_acc #(
    parameter int CELLS = crm_pkg::CELLS_DEFAULT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  crm_pkg::reading_t                         s_data,
    input  crm_pkg::cell_win_t [1:0]                  cell_win,
    output logic                                      scan_valid,
    input  logic                                      scan_take,
    output crm_pkg::scan_info_t                       scan_info,
    output logic [crm_pkg::VAL_W+$clog2(CELLS)-1:0]   scan_sum
);

    localparam int CNT_W = $clog2(CELLS);
    localparam int SUM_W = crm_pkg::VAL_W + CNT_W;

    logic                      in_valid_reg, in_valid_next;
    crm_pkg::reading_t         in_data_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      fault_reg, fault_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [crm_pkg::VAL_W-1:0] value_reg, value_next;
    logic                      scan_valid_reg, scan_valid_next;
    crm_pkg::scan_info_t       scan_info_reg, scan_info_next;
    logic [SUM_W-1:0]          scan_sum_reg, scan_sum_next;

    crm_pkg::cell_win_t        win;
    logic                      last, bad, fault_now, in_go, scan_free, in_beat;
    logic [CNT_W-1:0]          idx_now;
    logic [crm_pkg::VAL_W-1:0] value_now;
    logic [SUM_W-1:0]          sum_now;

    assign scan_free = !scan_valid_reg || scan_take;
    assign last      = (count_reg == CNT_W'(CELLS - 1));
    // only the closing sample of a scan needs room in the summary register
    assign in_go     = in_valid_reg && (!last || scan_free);
    assign s_ready   = !in_valid_reg || in_go;
    assign in_beat   = s_valid && s_ready;

    always_comb begin
        win       = cell_win[in_data_reg.reading_kind];
        bad       = (in_data_reg.reading_value < win.lo) || (in_data_reg.reading_value > win.hi);
        fault_now = fault_reg || bad;
        idx_now   = fault_reg ? idx_reg : count_reg;
        value_now = fault_reg ? value_reg : in_data_reg.reading_value;
        sum_now   = sum_reg + SUM_W'(in_data_reg.reading_value);

        in_valid_next   = in_beat ? 1'b1 : (in_go ? 1'b0 : in_valid_reg);
        count_next      = count_reg;
        sum_next        = sum_reg;
        fault_next      = fault_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        scan_valid_next = scan_take ? 1'b0 : scan_valid_reg;
        scan_info_next  = scan_info_reg;
        scan_sum_next   = scan_sum_reg;

        if (in_go) begin
            if (last) begin
                count_next                = '0;
                sum_next                  = '0;
                fault_next                = 1'b0;
                scan_valid_next           = 1'b1;
                scan_info_next.kind       = in_data_reg.reading_kind;
                scan_info_next.cell_fault = fault_now;
                scan_info_next.cell_index = crm_pkg::IDX_W'(idx_now);
                scan_info_next.cell_value = value_now;
                scan_sum_next             = sum_now;
            end else begin
                count_next = count_reg + CNT_W'(1);
                fault_next = fault_now;
                idx_next   = idx_now;
                value_next = value_now;
                if (!fault_now) begin
                    sum_next = sum_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            fault_reg      <= 1'b0;
            scan_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            fault_reg      <= fault_next;
            scan_valid_reg <= scan_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            in_data_reg <= s_data;
        end
        idx_reg       <= idx_next;
        value_reg     <= value_next;
        scan_info_reg <= scan_info_next;
        scan_sum_reg  <= scan_sum_next;
    end

    assign scan_valid = scan_valid_reg;
    assign scan_info  = scan_info_reg;
    assign scan_sum   = scan_sum_reg;

endmodule

>>> hdl/crm_verdict.sv
// mean bound check, truncated mean and result register
module crm_verdict #(
    parameter int CELLS = crm_pkg::CELLS_DEFAULT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      scan_valid,
    output logic                                      scan_take,
    input  crm_pkg::scan_info_t                       scan_info,
    input  logic [crm_pkg::VAL_W+$clog2(CELLS)-1:0]   scan_sum,
    input  logic [1:0][crm_pkg::VAL_W+$clog2(CELLS)-1:0] mean_lo,
    input  logic [1:0][crm_pkg::VAL_W+$clog2(CELLS)-1:0] mean_hi,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output crm_pkg::verdict_t                         m_data
);

    localparam int CNT_W      = $clog2(CELLS);
    localparam int SUM_W      = crm_pkg::VAL_W + CNT_W;
    localparam int RECIP_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int MEAN_SHIFT = SUM_W + CNT_W;
    // ceil(2^shift / cells) gives the exact floor quotient for every sum below 2^SUM_W
    localparam longint unsigned RECIP =
        ((64'd1 << MEAN_SHIFT) + 64'(CELLS) - 64'd1) / 64'(CELLS);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic              m_valid_reg, m_valid_next;
    crm_pkg::verdict_t m_data_reg, m_data_next;

    logic [PROD_W-1:0]         prod;
    logic [crm_pkg::VAL_W-1:0] mean;
    logic                      mean_bad;
    logic [1:0]                kind_code;

    assign scan_take = scan_valid && (!m_valid_reg || m_ready);

    always_comb begin
        prod      = PROD_W'(scan_sum) * PROD_W'(RECIP_V);
        mean      = prod[MEAN_SHIFT +: crm_pkg::VAL_W];
        mean_bad  = (scan_sum < mean_lo[scan_info.kind]) || (scan_sum > mean_hi[scan_info.kind]);
        kind_code = scan_info.kind ? crm_pkg::FAULT_TEMP : crm_pkg::FAULT_VOLT;

        m_data_next = '0;
        if (scan_info.cell_fault) begin
            m_data_next.fault_kind  = kind_code;
            m_data_next.cell_index  = scan_info.cell_index;
            m_data_next.fault_value = scan_info.cell_value;
        end else if (mean_bad) begin
            m_data_next.fault_kind  = kind_code;
            m_data_next.on_mean     = 1'b1;
            m_data_next.fault_value = mean;
        end

        m_valid_next = scan_take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_take) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/cell_range_and_average_monitor.sv
// top level of the cell range and average monitor
//
//  port group   dir  handshake          payload
//  s_           in   s_valid/s_ready    reading_t: reading_kind, reading_value
//  m_           out  m_valid/m_ready    verdict_t: fault_kind, on_mean, cell_index, fault_value
//  cfg_wr_      in   cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// one reading per cycle unless a scan end stalls; window check and accumulate sit behind
// the input register; a scan's verdict then passes the summary and result registers
// the reported mean costs one multiply by a reciprocal between summary and result registers
// synchronous active-low reset restores thresholds and clears the scan in progress
// a held result stalls the input only once the summary stage is also full at a scan end
module cell_range_and_average_monitor #(
    parameter int CELLS = crm_pkg::CELLS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  crm_pkg::reading_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output crm_pkg::verdict_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [crm_pkg::REG_IDX_W-1:0] cfg_wr_index,
    input  logic [crm_pkg::VAL_W-1:0]     cfg_wr_data
);

    localparam int SUM_W = crm_pkg::VAL_W + $clog2(CELLS);

    crm_pkg::cell_win_t [1:0] cell_win;
    logic [1:0][SUM_W-1:0]    mean_lo;
    logic [1:0][SUM_W-1:0]    mean_hi;
    logic                     scan_valid;
    logic                     scan_take;
    crm_pkg::scan_info_t      scan_info;
    logic [SUM_W-1:0]         scan_sum;

    crm_cfg #(
        .CELLS(CELLS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .cell_win    (cell_win),
        .mean_lo     (mean_lo),
        .mean_hi     (mean_hi)
    );

    crm_acc #(
        .CELLS(CELLS)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cell_win  (cell_win),
        .scan_valid(scan_valid),
        .scan_take (scan_take),
        .scan_info (scan_info),
        .scan_sum  (scan_sum)
    );

    crm_verdict #(
        .CELLS(CELLS)
    ) u_verdict (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_valid(scan_valid),
        .scan_take (scan_take),
        .scan_info (scan_info),
        .scan_sum  (scan_sum),
        .mean_lo   (mean_lo),
        .mean_hi   (mean_hi),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a clean scan reports all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.fault_kind == crm_pkg::FAULT_NONE) |->
            !m_data.on_mean && (m_data.cell_index == '0) && (m_data.fault_value == '0))
        else $error("clean verdict carries fault detail");

    // a mean fault names a kind and no cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.on_mean |->
            (m_data.fault_kind != crm_pkg::FAULT_NONE) && (m_data.cell_index == '0))
        else $error("mean fault with bad kind or cell index");

    // only the defined fault codes leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fault_kind == crm_pkg::FAULT_NONE) ||
                    (m_data.fault_kind == crm_pkg::FAULT_VOLT) ||
                    (m_data.fault_kind == crm_pkg::FAULT_TEMP))
        else $error("undefined fault kind");

    // a summary taken by the result stage must show up as a result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_take |=> m_valid)
        else $error("summary taken but no result beat");

endmodule

>>> verif/tb_cell_range_and_average_monitor.sv
// self-checking testbench for the cell range and average monitor
`timescale 1ns / 100ps

module tb_cell_range_and_average_monitor;

    import crm_pkg::*;

    localparam int N_CELLS = CELLS_DEFAULT;
    localparam int N_REGS  = 8;
    localparam int NO_BAD  = -1;

    // one directed scan: a fill value with an optional odd sample
    typedef struct {
        logic             kind;
        logic [VAL_W-1:0] fill;
        int               bad_pos;
        logic [VAL_W-1:0] bad_val;
        bit               flip_last;
        bit               pinned;
        verdict_t         want;
    } scan_row_t;

    typedef struct {
        bit       pinned;
        verdict_t want;
    } pinned_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    reading_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    verdict_t             m_data;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_wr_index;
    logic [VAL_W-1:0]     cfg_wr_data;

    bit  steady = 1'b0;
    int  fail_cnt = 0;

    // predictor state
    logic [VAL_W-1:0] thr [N_REGS];
    int               scan_cnt;
    int               scan_sum;
    bit               cell_flag;
    logic [IDX_W-1:0] held_idx;
    logic [VAL_W-1:0] held_val;
    verdict_t         verdict_q [$];
    pinned_t          pinned_q [$];

    // thresholds the stimulus is currently using
    logic [VAL_W-1:0] cur_cfg [N_REGS];

    scan_row_t dir_rows [21] = '{
        '{KIND_VOLT, 12'd150,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}},
        '{KIND_VOLT, 12'd150,  0,      12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b0, 5'd0,  12'd0}},
        '{KIND_VOLT, 12'd150,  31,     12'd4095, 1'b0, 1'b1, '{FAULT_VOLT, 1'b0, 5'd31, 12'd4095}},
        '{KIND_VOLT, 12'd4095, NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b0, 5'd0,  12'd4095}},
        '{KIND_VOLT, 12'd99,   NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b0, 5'd0,  12'd99}},
        '{KIND_VOLT, 12'd241,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b0, 5'd0,  12'd241}},
        '{KIND_VOLT, 12'd100,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd100}},
        '{KIND_VOLT, 12'd240,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd240}},
        '{KIND_VOLT, 12'd120,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}},
        '{KIND_VOLT, 12'd220,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}},
        '{KIND_VOLT, 12'd119,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd119}},
        '{KIND_VOLT, 12'd221,  NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd221}},
        '{KIND_VOLT, 12'd119,  9,      12'd150,  1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd119}},
        '{KIND_VOLT, 12'd220,  4,      12'd221,  1'b0, 1'b1, '{FAULT_VOLT, 1'b1, 5'd0,  12'd220}},
        '{KIND_TEMP, 12'd70,   NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}},
        '{KIND_TEMP, 12'd85,   NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_TEMP, 1'b1, 5'd0,  12'd85}},
        '{KIND_TEMP, 12'd50,   NO_BAD, 12'd0,    1'b0, 1'b1, '{FAULT_TEMP, 1'b1, 5'd0,  12'd50}},
        '{KIND_TEMP, 12'd70,   5,      12'd49,   1'b0, 1'b1, '{FAULT_TEMP, 1'b0, 5'd5,  12'd49}},
        '{KIND_TEMP, 12'd70,   17,     12'd86,   1'b0, 1'b1, '{FAULT_TEMP, 1'b0, 5'd17, 12'd86}},
        // mixed kinds: last sample decides the kind and the mean bounds
        '{KIND_VOLT, 12'd150,  NO_BAD, 12'd0,    1'b1, 1'b0, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}},
        '{KIND_TEMP, 12'd70,   31,     12'd110,  1'b1, 1'b0, '{FAULT_NONE, 1'b0, 5'd0,  12'd0}}
    };

    cell_range_and_average_monitor #(.CELLS(N_CELLS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99, 0) >= 32);
    end

    task automatic clear_scan();
        scan_cnt  = 0;
        scan_sum  = 0;
        cell_flag = 1'b0;
        held_idx  = '0;
        held_val  = '0;
    endtask

    // window check and accumulate for one accepted beat, closing each scan with its predicted verdict
    task automatic take_reading(input reading_t r);
        logic [VAL_W-1:0] cmin, cmax, mmin, mmax;
        int               lo, hi;
        fault_t           fk;
        verdict_t         v;
        pinned_t          pv;
        cmin = r.reading_kind ? thr[REG_TEMP_CELL_MIN] : thr[REG_VOLT_CELL_MIN];
        cmax = r.reading_kind ? thr[REG_TEMP_CELL_MAX] : thr[REG_VOLT_CELL_MAX];
        mmin = r.reading_kind ? thr[REG_TEMP_MEAN_MIN] : thr[REG_VOLT_MEAN_MIN];
        mmax = r.reading_kind ? thr[REG_TEMP_MEAN_MAX] : thr[REG_VOLT_MEAN_MAX];
        fk   = r.reading_kind ? FAULT_TEMP : FAULT_VOLT;
        if (!cell_flag) begin
            if (r.reading_value < cmin || r.reading_value > cmax) begin
                cell_flag = 1'b1;
                held_idx  = IDX_W'(scan_cnt);
                held_val  = r.reading_value;
            end else begin
                scan_sum = scan_sum + int'(r.reading_value);
            end
        end
        scan_cnt++;
        if (scan_cnt == N_CELLS) begin
            v  = '0;
            lo = int'(mmin) * N_CELLS;
            hi = int'(mmax) * N_CELLS;
            if (cell_flag) begin
                v.fault_kind  = fk;
                v.cell_index  = held_idx;
                v.fault_value = held_val;
            end else if (scan_sum < lo || scan_sum > hi) begin
                v.fault_kind  = fk;
                v.on_mean     = 1'b1;
                v.fault_value = VAL_W'(scan_sum / N_CELLS);
            end
            if (pinned_q.size() != 0) begin
                pv = pinned_q.pop_front();
                if (pv.pinned) v = pv.want;
            end
            verdict_q.push_back(v);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr[REG_VOLT_CELL_MIN] = VOLT_CELL_MIN_RST;
            thr[REG_VOLT_CELL_MAX] = VOLT_CELL_MAX_RST;
            thr[REG_VOLT_MEAN_MIN] = VOLT_MEAN_MIN_RST;
            thr[REG_VOLT_MEAN_MAX] = VOLT_MEAN_MAX_RST;
            thr[REG_TEMP_CELL_MIN] = TEMP_CELL_MIN_RST;
            thr[REG_TEMP_CELL_MAX] = TEMP_CELL_MAX_RST;
            thr[REG_TEMP_MEAN_MIN] = TEMP_MEAN_MIN_RST;
            thr[REG_TEMP_MEAN_MAX] = TEMP_MEAN_MAX_RST;
            clear_scan();
        end else begin
            if (cfg_wr_en) thr[cfg_wr_index] = cfg_wr_data;
            if (s_valid && s_ready) take_reading(s_data);
        end
    end

    task automatic check_field(input string fname, input int got, input int want);
        if (got != want) begin
            $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict expected none got %h", $time, m_data);
                fail_cnt++;
            end else begin
                want = verdict_q.pop_front();
                check_field("fault_kind", int'(m_data.fault_kind), int'(want.fault_kind));
                check_field("on_mean", int'(m_data.on_mean), int'(want.on_mean));
                check_field("cell_index", int'(m_data.cell_index), int'(want.cell_index));
                check_field("fault_value", int'(m_data.fault_value), int'(want.fault_value));
            end
        end
    end

    task automatic push_reading(input logic kind, input logic [VAL_W-1:0] val);
        @(negedge aclk);
        while (!steady && $urandom_range(99, 0) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{reading_kind: kind, reading_value: val};
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, let every verdict come back, then give the pipeline time to settle
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_kind_cfg(input logic kind, input logic [VAL_W-1:0] cmin,
                                input logic [VAL_W-1:0] cmax, input logic [VAL_W-1:0] mmin,
                                input logic [VAL_W-1:0] mmax);
        if (kind) begin
            cur_cfg[REG_TEMP_CELL_MIN] = cmin;
            cur_cfg[REG_TEMP_CELL_MAX] = cmax;
            cur_cfg[REG_TEMP_MEAN_MIN] = mmin;
            cur_cfg[REG_TEMP_MEAN_MAX] = mmax;
        end else begin
            cur_cfg[REG_VOLT_CELL_MIN] = cmin;
            cur_cfg[REG_VOLT_CELL_MAX] = cmax;
            cur_cfg[REG_VOLT_MEAN_MIN] = mmin;
            cur_cfg[REG_VOLT_MEAN_MAX] = mmax;
        end
    endtask

    task automatic plan_config(input int phase);
        int cmin, cmax, mmin, mmax;
        for (int k = 0; k < 2; k++) begin
            case (phase)
                0: set_kind_cfg(k[0], '0, '0, '0, '0);
                1: set_kind_cfg(k[0], '1, '1, '1, '1);
                2: set_kind_cfg(k[0], '1, '0, '1, '0);  // inverted windows
                3: set_kind_cfg(k[0], '0, '1, '0, '1);
                default: begin
                    cmin = $urandom_range(3000, 0);
                    cmax = cmin + $urandom_range(1000, 0);
                    if (cmax > 4095) cmax = 4095;
                    mmin = $urandom_range(cmax, cmin);
                    mmax = $urandom_range(cmax, mmin);
                    set_kind_cfg(k[0], VAL_W'(cmin), VAL_W'(cmax), VAL_W'(mmin), VAL_W'(mmax));
                end
            endcase
        end
    endtask

    task automatic write_cfg();
        reg_idx_t r;
        r = r.first();
        do begin
            @(negedge aclk);
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= r;
            cfg_wr_data  <= cur_cfg[r];
            r = r.next();
        end while (r != r.first());
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] cell_lo(input logic kind);
        return kind ? cur_cfg[REG_TEMP_CELL_MIN] : cur_cfg[REG_VOLT_CELL_MIN];
    endfunction

    function automatic logic [VAL_W-1:0] cell_hi(input logic kind);
        return kind ? cur_cfg[REG_TEMP_CELL_MAX] : cur_cfg[REG_VOLT_CELL_MAX];
    endfunction

    function automatic logic [VAL_W-1:0] pick_in(input logic kind);
        logic [VAL_W-1:0] lo, hi;
        lo = cell_lo(kind);
        hi = cell_hi(kind);
        if (lo <= hi) return VAL_W'($urandom_range(hi, lo));
        return VAL_W'($urandom_range(4095, 0));
    endfunction

    // just past the low or high edge of the window where that edge exists, else (or on a third of the draws) anything
    function automatic logic [VAL_W-1:0] pick_out(input logic kind);
        logic [VAL_W-1:0] lo, hi;
        int               sel;
        lo  = cell_lo(kind);
        hi  = cell_hi(kind);
        sel = $urandom_range(2, 0);
        if (sel == 0 && lo != '0) return lo - 1'b1;
        if (sel == 1 && hi != '1) return hi + 1'b1;
        return VAL_W'($urandom_range(4095, 0));
    endfunction

    task automatic random_scan();
        logic             kind, k;
        logic [VAL_W-1:0] v, tgt;
        int               mode, bad1, bad2;
        kind = 1'($urandom_range(1, 0));
        mode = $urandom_range(99, 0);
        bad1 = $urandom_range(N_CELLS - 1, 0);
        bad2 = $urandom_range(N_CELLS - 1, 0);
        // target at or just past a mean bound; some scans fill with it, one sample nudged by up to one
        case ($urandom_range(3, 0))
            0: tgt = kind ? cur_cfg[REG_TEMP_MEAN_MIN] : cur_cfg[REG_VOLT_MEAN_MIN];
            1: tgt = kind ? cur_cfg[REG_TEMP_MEAN_MAX] : cur_cfg[REG_VOLT_MEAN_MAX];
            2: tgt = (kind ? cur_cfg[REG_TEMP_MEAN_MIN] : cur_cfg[REG_VOLT_MEAN_MIN]) - 1'b1;
            default: tgt = (kind ? cur_cfg[REG_TEMP_MEAN_MAX] : cur_cfg[REG_VOLT_MEAN_MAX]) + 1'b1;
        endcase
        for (int i = 0; i < N_CELLS; i++) begin
            k = kind;
            if (mode < 40) begin
                v = pick_in(k);
            end else if (mode < 55) begin
                v = (i == bad1) ? tgt + VAL_W'($urandom_range(2, 0)) - 1'b1 : tgt;
            end else if (mode < 75) begin
                v = (i == bad1 || i == bad2) ? pick_out(k) : pick_in(k);
            end else if (mode < 88) begin
                v = VAL_W'($urandom_range(4095, 0));
            end else begin
                k = 1'($urandom_range(1, 0));
                v = pick_in(k);
            end
            push_reading(k, v);
        end
    endtask

    initial begin
        logic             k;
        logic [VAL_W-1:0] v;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed scans on the reset thresholds
        foreach (dir_rows[r]) begin
            pinned_q.push_back('{dir_rows[r].pinned, dir_rows[r].want});
            for (int i = 0; i < N_CELLS; i++) begin
                k = dir_rows[r].kind;
                v = (i == dir_rows[r].bad_pos) ? dir_rows[r].bad_val : dir_rows[r].fill;
                if (dir_rows[r].flip_last && i == N_CELLS - 1) k = ~k;
                push_reading(k, v);
            end
        end

        // extremes first, then random windows
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            steady = (phase == 3 || phase == 4);
            plan_config(phase);
            write_cfg();
            repeat ((phase < 4) ? 1 : 2) random_scan();
        end
        wait_drained();

        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
